// ===== sv/wsd_pkg.sv =====
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int LEN_BITS = 64;
  localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);

  localparam logic [6:0] LEN7_MASK  = 7'h7f;
  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [2:0] EXT16_CNT  = 3'd1;
  localparam logic [2:0] EXT64_CNT  = 3'd7;
  localparam logic [2:0] KEY_CNT    = 3'd3;

  typedef enum logic [4:0] {
    PH_HEAD0   = 5'b00001,
    PH_HEAD1   = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
  } flags_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  hcnt;
    logic [63:0] len;
    logic [31:0] key;
    logic [63:0] remain;
    logic [1:0]  kidx;
    flags_t      flags;
  } state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_payload;
    logic        header_done;
    logic        frame_fin;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        frame_masked;
    logic [63:0] frame_length;
    logic        frame_end;
  } result_t;

  localparam state_t STATE_RST = '{
    phase:  PH_HEAD0,
    hcnt:   3'd0,
    len:    64'd0,
    key:    32'd0,
    remain: 64'd0,
    kidx:   2'd0,
    flags:  '0
  };

  function automatic logic [63:0] sat_len(input logic [63:0] v);
    logic [63:0] r;
    r = (v > LEN_MAX) ? LEN_MAX : v;
    return r;
  endfunction

endpackage

// ===== sv/wsd_parse.sv =====
`timescale 1ns / 1ps

module wsd_parse
  import wsd_pkg::*;
(
  input  state_t      st,
  input  logic [7:0]  in_byte,
  output state_t      st_nxt,
  output result_t     res
);

  logic [7:0]  key_byte;
  logic [31:0] key_shift;
  logic [63:0] len_sat;
  logic [63:0] len_shift;
  logic [63:0] remain_dec;
  logic        hdone;
  logic        fend;
  logic        payload;
  logic [7:0]  data;

  always_comb begin
    st_nxt     = st;
    hdone      = 1'b0;
    fend       = 1'b0;
    payload    = 1'b0;
    data       = 8'd0;
    key_shift  = st.key << {st.kidx, 3'b000};
    key_byte   = key_shift[31:24];
    len_shift  = {st.len[55:0], in_byte};
    len_sat    = 64'd0;
    remain_dec = (st.remain != 64'd0) ? (st.remain - 64'd1) : st.remain;

    case (st.phase)
      PH_HEAD1: begin
        st_nxt.flags.masked = in_byte[7];
        st_nxt.key          = 32'd0;
        st_nxt.len          = {57'd0, in_byte[6:0] & LEN7_MASK};
        if (in_byte[6:0] == LEN16_CODE) begin
          st_nxt.len   = 64'd0;
          st_nxt.hcnt  = EXT16_CNT;
          st_nxt.phase = PH_EXTLEN;
        end else if (in_byte[6:0] > LEN16_CODE) begin
          st_nxt.len   = 64'd0;
          st_nxt.hcnt  = EXT64_CNT;
          st_nxt.phase = PH_EXTLEN;
        end else if (in_byte[7]) begin
          st_nxt.hcnt  = KEY_CNT;
          st_nxt.phase = PH_KEY;
        end else begin
          hdone = 1'b1;
        end
      end
      PH_EXTLEN: begin
        st_nxt.len = len_shift;
        if (st.hcnt != 3'd0) begin
          st_nxt.hcnt = st.hcnt - 3'd1;
        end else if (st.flags.masked) begin
          st_nxt.hcnt  = KEY_CNT;
          st_nxt.phase = PH_KEY;
        end else begin
          hdone = 1'b1;
        end
      end
      PH_KEY: begin
        st_nxt.key = {st.key[23:0], in_byte};
        if (st.hcnt != 3'd0) begin
          st_nxt.hcnt = st.hcnt - 3'd1;
        end else begin
          hdone = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        data          = in_byte ^ key_byte;
        payload       = 1'b1;
        st_nxt.kidx   = st.kidx + 2'd1;
        st_nxt.remain = remain_dec;
        if (remain_dec == 64'd0) begin
          fend         = 1'b1;
          st_nxt.phase = PH_HEAD0;
        end
      end
      default: begin
        st_nxt.flags.fin    = in_byte[7];
        st_nxt.flags.rsv    = in_byte[6:4];
        st_nxt.flags.opcode = in_byte[3:0];
        st_nxt.flags.masked = 1'b0;
        st_nxt.len          = 64'd0;
        st_nxt.remain       = 64'd0;
        st_nxt.key          = 32'd0;
        st_nxt.kidx         = 2'd0;
        st_nxt.hcnt         = 3'd0;
        st_nxt.phase        = PH_HEAD1;
      end
    endcase

    // end of header: clamp length, then payload or a new frame
    if (hdone) begin
      len_sat     = sat_len(st_nxt.len);
      st_nxt.len  = len_sat;
      st_nxt.kidx = 2'd0;
      if (len_sat == 64'd0) begin
        fend         = 1'b1;
        st_nxt.phase = PH_HEAD0;
      end else begin
        st_nxt.remain = len_sat;
        st_nxt.phase  = PH_PAYLOAD;
      end
    end

    res.data_byte     = data;
    res.is_payload    = payload;
    res.header_done   = hdone;
    res.frame_fin     = st_nxt.flags.fin;
    res.reserved_bits = st_nxt.flags.rsv;
    res.frame_opcode  = st_nxt.flags.opcode;
    res.frame_masked  = st_nxt.flags.masked;
    res.frame_length  = st_nxt.len;
    res.frame_end     = fend;
  end

endmodule

// ===== sv/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// result: registered, on the out_ ports in the cycle after its input transfer
// throughput: one byte per cycle while out_ready holds; the parser state and result register update together
// in_ready stays high while the result register is empty or being drained
// reset: synchronous active-low rst_n; parser returns to first header byte,
// result register empties

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_is_payload,
  output logic        out_header_done,
  output logic        out_frame_fin,
  output logic [2:0]  out_reserved_bits,
  output logic [3:0]  out_frame_opcode,
  output logic        out_frame_masked,
  output logic [63:0] out_frame_length,
  output logic        out_frame_end
);

  state_t  st_r;
  state_t  st_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    out_valid_r;
  logic    in_xfer;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  wsd_parse u_parse (
    .st      (st_r),
    .in_byte (in_byte),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= STATE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_byte     = res_r.data_byte;
  assign out_is_payload    = res_r.is_payload;
  assign out_header_done   = res_r.header_done;
  assign out_frame_fin     = res_r.frame_fin;
  assign out_reserved_bits = res_r.reserved_bits;
  assign out_frame_opcode  = res_r.frame_opcode;
  assign out_frame_masked  = res_r.frame_masked;
  assign out_frame_length  = res_r.frame_length;
  assign out_frame_end     = res_r.frame_end;

  // payload phase holds exactly while bytes remain
  a_remain_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_PAYLOAD) == (st_r.remain != 64'd0))
    else $error("payload phase and remaining count disagree");

  a_no_hdr_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.is_payload && res_r.header_done))
    else $error("byte marked both payload and header end");

  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_end && !res_r.is_payload)
      |-> (res_r.header_done && res_r.frame_length == 64'd0))
    else $error("header-only frame end without zero length");

  a_hdr_to_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && res_nxt.header_done && !res_nxt.frame_end)
      |=> (st_r.phase == PH_PAYLOAD))
    else $error("header end did not enter payload");

endmodule
